/* src/rbsi_pkg.sv */
// Package for the ray/box slab test: widths, sentinels and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;
  localparam int FLD_W     = 32;
  // |corner - origin| < 2^32 and |dir| <= 2^31 both fit in 32 unsigned bits
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 32;
  localparam int REM_W     = DEN_W;
  localparam int QW        = NUM_W + FRAC_BITS;   // quotient magnitude bits
  localparam int QS_W      = QW + 1;              // signed quotient
  localparam int DIV_LAT   = QW + 1;              // bit stages plus sign stage
  localparam int RED_LAT   = 4;
  localparam int LAST      = DIV_LAT + RED_LAT;   // index of the output stage

  typedef logic signed [QS_W-1:0] quo_t;

  // Quotients stay strictly inside (-2^(QS_W-1), 2^(QS_W-1)), so the extremes
  // stand in for minus and plus infinity.
  localparam quo_t NEG_SENT = {1'b1, {(QS_W-1){1'b0}}};
  localparam quo_t POS_SENT = {1'b0, {(QS_W-1){1'b1}}};
  localparam quo_t Q_MAX_W  = {{(QS_W-31){1'b0}}, {31{1'b1}}};
  localparam quo_t Q_MIN_W  = {{(QS_W-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic [AXES-1:0] dir_zero;
    logic            outside;
  } slab_flags_t;

endpackage
`default_nettype wire

/* src/rbsi_div.sv */
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, sign applied in a final stage. Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div
  import rbsi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic             neg_i,
  output quo_t                  quo_o
);

  logic [REM_W-1:0] rem_q [1:QW];
  logic [QW-1:0]    dvd_q [1:QW];
  logic [QW-1:0]    quo_q [1:QW];
  logic [DEN_W-1:0] den_q [1:QW];
  logic             neg_q [1:QW];
  quo_t             quo_s_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [QW-1:0]    dvd_in;
    logic [QW-1:0]    quo_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {num_i, {FRAC_BITS{1'b0}}};
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k];
      assign dvd_in = dvd_q[k];
      assign quo_in = quo_q[k];
      assign den_in = den_q[k];
      assign neg_in = neg_q[k];
    end

    assign trial = {rem_in, dvd_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        dvd_q[k+1] <= {dvd_in[QW-2:0], 1'b0};
        quo_q[k+1] <= {quo_in[QW-2:0], ge};
        den_q[k+1] <= den_in;
        neg_q[k+1] <= neg_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_s_q <= neg_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});
    end
  end

  assign quo_o = quo_s_q;

endmodule
`default_nettype wire

/* src/rbsi_reduce.sv */
// Slab reduction: order per axis, max entry / min exit over axes, hit test
// and saturation into the output register. Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_reduce
  import rbsi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire quo_t        lo_i [AXES],
  input  wire quo_t        hi_i [AXES],
  input  wire slab_flags_t flags_i,
  output logic             hit_o,
  output logic [FLD_W-1:0] t_entry_o
);

  quo_t tn_q [AXES];
  quo_t tf_q [AXES];
  logic out1_q;
  quo_t e01_q, l01_q, tn2_q, tf2_q;
  logic out2_q;
  quo_t entry_q, leave_q;
  logic out3_q;
  logic hit_q;
  logic [FLD_W-1:0] t_entry_q;

  quo_t e01_d, l01_d, entry_d, leave_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < AXES; a++) begin
        if (flags_i.dir_zero[a]) begin
          tn_q[a] <= NEG_SENT;
          tf_q[a] <= POS_SENT;
        end else if (lo_i[a] < hi_i[a]) begin
          tn_q[a] <= lo_i[a];
          tf_q[a] <= hi_i[a];
        end else begin
          tn_q[a] <= hi_i[a];
          tf_q[a] <= lo_i[a];
        end
      end
      out1_q <= flags_i.outside;
    end
  end

  assign e01_d = (tn_q[0] > tn_q[1]) ? tn_q[0] : tn_q[1];
  assign l01_d = (tf_q[0] < tf_q[1]) ? tf_q[0] : tf_q[1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e01_q  <= e01_d;
      l01_q  <= l01_d;
      tn2_q  <= tn_q[2];
      tf2_q  <= tf_q[2];
      out2_q <= out1_q;
    end
  end

  assign entry_d = (e01_q > tn2_q) ? e01_q : tn2_q;
  assign leave_d = (l01_q < tf2_q) ? l01_q : tf2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      leave_q <= leave_d;
      out3_q  <= out2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= !out3_q && (leave_q >= entry_q) && (entry_q > quo_t'(0));
      if (entry_q > Q_MAX_W)      t_entry_q <= Q_MAX_W[FLD_W-1:0];
      else if (entry_q < Q_MIN_W) t_entry_q <= Q_MIN_W[FLD_W-1:0];
      else                        t_entry_q <= entry_q[FLD_W-1:0];
    end
  end

  assign hit_o     = hit_q;
  assign t_entry_o = t_entry_q;

endmodule
`default_nettype wire

/* src/ray_box_slab_intersect_top.sv */
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_div and rbsi_reduce.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | ray origin, direction, box min and max corners (12 x Q16.16)
//  m_axis   | out | hit flag and entry distance (Q16.16, saturated)
//
// One beat enters per cycle while the output is not stalled; each result passes the
// input registers, the bit-per-stage dividers and the reduction stages before it leaves.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// A stalled output freezes every stage at once, so nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect_top
  import rbsi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 b each)
  input  wire logic [383:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [0] hit, [32:1] t_entry, [39:33] zero
  output logic [39:0]       m_axis_tdata_o
);

  logic        en;
  logic        v_q [0:LAST];
  slab_flags_t flags_q [0:DIV_LAT];
  slab_flags_t flags_d;
  logic [AXES-1:0] dir_zero;
  logic            outside;

  logic [NUM_W-1:0] num_q [LANES];
  logic             neg_q [LANES];
  logic [DEN_W-1:0] den_q [AXES];
  quo_t             quo_lo [AXES];
  quo_t             quo_hi [AXES];
  logic             hit;
  logic [FLD_W-1:0] t_entry;

  // Advance the whole pipeline unless a finished result is held back.
  assign en              = !v_q[LAST] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [FLD_W-1:0] org, dir, lo, hi;
    logic signed [FLD_W:0]   d_lo, d_hi, a_lo, a_hi;
    logic signed [FLD_W:0]   dir_w, a_dir;

    assign org   = s_axis_tdata_i[FLD_W*a +: FLD_W];
    assign dir   = s_axis_tdata_i[FLD_W*(AXES+a) +: FLD_W];
    assign lo    = s_axis_tdata_i[FLD_W*(2*AXES+a) +: FLD_W];
    assign hi    = s_axis_tdata_i[FLD_W*(3*AXES+a) +: FLD_W];
    assign d_lo  = {lo[FLD_W-1], lo} - {org[FLD_W-1], org};
    assign d_hi  = {hi[FLD_W-1], hi} - {org[FLD_W-1], org};
    assign dir_w = {dir[FLD_W-1], dir};
    assign a_lo  = d_lo[FLD_W] ? -d_lo : d_lo;
    assign a_hi  = d_hi[FLD_W] ? -d_hi : d_hi;
    assign a_dir = dir[FLD_W-1] ? -dir_w : dir_w;

    assign dir_zero[a] = (dir == '0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[2*a]   <= a_lo[NUM_W-1:0];
        num_q[2*a+1] <= a_hi[NUM_W-1:0];
        neg_q[2*a]   <= d_lo[FLD_W] ^ dir[FLD_W-1];
        neg_q[2*a+1] <= d_hi[FLD_W] ^ dir[FLD_W-1];
        den_q[a]     <= a_dir[DEN_W-1:0];
      end
    end

    rbsi_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[2*a]),
      .den_i (den_q[a]),
      .neg_i (neg_q[2*a]),
      .quo_o (quo_lo[a])
    );

    rbsi_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[2*a+1]),
      .den_i (den_q[a]),
      .neg_i (neg_q[2*a+1]),
      .quo_o (quo_hi[a])
    );
  end

  // A zero-direction axis misses when the origin lies outside its slab.
  always_comb begin
    outside = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (dir_zero[a] &&
          (($signed(s_axis_tdata_i[FLD_W*a +: FLD_W]) <
            $signed(s_axis_tdata_i[FLD_W*(2*AXES+a) +: FLD_W])) ||
           ($signed(s_axis_tdata_i[FLD_W*a +: FLD_W]) >
            $signed(s_axis_tdata_i[FLD_W*(3*AXES+a) +: FLD_W])))) begin
        outside = 1'b1;
      end
    end
  end

  assign flags_d = '{dir_zero: dir_zero, outside: outside};

  // Carry the slab flags alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_q[0] <= flags_d;
      for (int i = 1; i <= DIV_LAT; i++) flags_q[i] <= flags_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i <= LAST; i++) v_q[i] <= v_q[i-1];
    end
  end

  rbsi_reduce u_reduce (
    .clk_i     (clk_i),
    .en_i      (en),
    .lo_i      (quo_lo),
    .hi_i      (quo_hi),
    .flags_i   (flags_q[DIV_LAT]),
    .hit_o     (hit),
    .t_entry_o (t_entry)
  );

  assign m_axis_tvalid_o = v_q[LAST];
  assign m_axis_tdata_o  = {7'b0, t_entry, hit};

`ifndef SYNTH
  a_hit_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |->
      (!m_axis_tdata_o[32] && (m_axis_tdata_o[32:1] != '0)))
    else $error("hit reported with non-positive entry distance");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v_q[0]) && $stable(v_q[DIV_LAT]) && $stable(v_q[LAST])))
    else $error("pipeline moved during an output stall");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted beat did not enter the first stage");
`endif

endmodule
`default_nettype wire

/* tb/ray_box_slab_intersect_checker.sv */
// Checker for the ray/box slab test: watches both stream channels, predicts
// hit and entry distance per input beat and compares. Depends on rbsi_pkg.
`timescale 1ns / 1ps
module ray_box_slab_intersect_checker
  import rbsi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [383:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [39:0]  m_axis_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic        hit;
    logic [31:0] t_entry;
  } slab_result_t;

  slab_result_t expected_hits[$];

  function automatic longint slab_div(longint num, longint den);
    longint nm, dm, q;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q  = (nm <<< FRAC_BITS) / dm;
    return (((num < 0) != (den < 0)) ? -q : q);
  endfunction

  function automatic slab_result_t predict_slab(logic [383:0] d);
    longint entry, leave, org, dir, lo, hi, t1, t2, tn, tf;
    logic outside;
    slab_result_t r;
    entry = -(64'sd1 <<< 62);
    leave = 64'sd1 <<< 62;
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      org = longint'($signed(d[32*a +: 32]));
      dir = longint'($signed(d[32*(3+a) +: 32]));
      lo  = longint'($signed(d[32*(6+a) +: 32]));
      hi  = longint'($signed(d[32*(9+a) +: 32]));
      if (dir == 0) begin
        if (org < lo || org > hi) outside = 1'b1;
      end else begin
        t1 = slab_div(lo - org, dir);
        t2 = slab_div(hi - org, dir);
        tn = (t1 < t2) ? t1 : t2;
        tf = (t1 < t2) ? t2 : t1;
        if (tn > entry) entry = tn;
        if (tf < leave) leave = tf;
      end
    end
    r.hit = !outside && leave >= entry && entry > 0;
    if (entry > 64'sd2147483647) entry = 64'sd2147483647;
    if (entry < -64'sd2147483648) entry = -64'sd2147483648;
    r.t_entry = entry[31:0];
    return r;
  endfunction

  initial fail_count_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i) begin
    slab_result_t exp_r;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_hits.push_back(predict_slab(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata_i);
          errs++;
        end else begin
          exp_r = expected_hits.pop_front();
          if (m_axis_tdata_i[0] !== exp_r.hit) begin
            $error("hit: expected %0d actual %0d", exp_r.hit, m_axis_tdata_i[0]);
            errs++;
          end
          if (m_axis_tdata_i[32:1] !== exp_r.t_entry) begin
            $error("t_entry: expected %h actual %h", exp_r.t_entry,
                   m_axis_tdata_i[32:1]);
            errs++;
          end
        end
      end
    end
    if (errs != 0) fail_count_o <= fail_count_o + errs;
    pending_o <= expected_hits.size();
  end

endmodule

/* tb/ray_box_slab_intersect_top_test.sv */
// Testbench top for the ray/box slab test: drives rays and boxes with random
// gaps and stalls, and reports the verdict. Depends on the checker and the RTL.
`timescale 1ns / 1ps
module ray_box_slab_intersect_top_test;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [383:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  int           fail_count;
  int           pending;
  logic         stim_done = 1'b0;

  ray_box_slab_intersect_top uut (.*);

  ray_box_slab_intersect_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // No gap half the time, otherwise mostly short gaps and sometimes long ones.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick a coordinate: extremes, small values or fully random.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3, 4, 5: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom();
    endcase
  endfunction

  // Build one ray/box beat; mode 0 is random, others shape a plausible hit.
  function automatic logic [383:0] make_ray();
    logic [383:0] d;
    logic [31:0] a, b;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = pick_coord();
    if ($urandom_range(0, 3) != 0) begin
      for (int ax = 0; ax < 3; ax++) begin
        a = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        b = a + $urandom_range(1, 32'h0040_0000);
        d[32*(6+ax) +: 32] = a;
        d[32*(9+ax) +: 32] = b;
        d[32*ax +: 32] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        if ($urandom_range(0, 7) == 0) d[32*(3+ax) +: 32] = '0;
        else if ($urandom_range(0, 1))
          d[32*(3+ax) +: 32] = $urandom_range(1, 32'h0002_0000)
                               * ($urandom_range(0, 1) ? 1 : -1);
      end
    end
    return d;
  endfunction

  task automatic send_beat(logic [383:0] d);
    repeat (gap_len()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Output stalls at random, chosen anew on every clock.
  initial begin
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= (gap_len() == 0);
    end
  end

  initial begin
    logic [383:0] d;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: all-zero directions, zero-direction in and out of slab,
    // inverted box, extreme values, entry behind origin, saturation.
    send_beat('0);
    send_beat({12{32'h8000_0000}});
    send_beat({12{32'h7fff_ffff}});
    d = '0;
    d[32*3 +: 32] = 32'h0001_0000; d[32*6 +: 32] = 32'h0002_0000;
    d[32*9 +: 32] = 32'h0004_0000;
    send_beat(d);                        // x-only ray, origin inside y/z slabs
    d[32*4 +: 32] = 32'h0; d[32*7 +: 32] = 32'h0001_0000;
    d[32*10 +: 32] = 32'h0002_0000;
    send_beat(d);                        // zero y direction, origin outside
    d[32*6 +: 32] = 32'h0004_0000; d[32*9 +: 32] = 32'h0002_0000;
    send_beat(d);                        // inverted box
    d = '0;
    d[32*3 +: 32] = 32'h0000_0001; d[32*6 +: 32] = 32'h7fff_ffff;
    d[32*9 +: 32] = 32'h7fff_ffff;
    send_beat(d);                        // huge entry, saturates
    d[32*3 +: 32] = 32'hffff_ffff; d[32*6 +: 32] = 32'h8000_0000;
    d[32*9 +: 32] = 32'h7fff_ffff; d[32*0 +: 32] = 32'h7fff_ffff;
    send_beat(d);
    d[32*3 +: 32] = 32'h8000_0000;
    send_beat(d);
    d = '0;
    d[32*3 +: 32] = 32'h0001_0000; d[32*6 +: 32] = 32'hfffe_0000;
    d[32*9 +: 32] = 32'h0002_0000;
    send_beat(d);                        // origin inside, entry negative
    for (int i = 0; i < 2000; i++) send_beat(make_ray());
    s_axis_tvalid_i <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
